@@ hw/rtl/twg_pkg.sv @@
// Shared types, register indexes and codes for the test waveform generator.
package twg_pkg;

	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

	localparam logic [2:0] MODE_CONST = 3'd0;
	localparam logic [2:0] MODE_SINE  = 3'd1;
	localparam logic [2:0] MODE_RAMP  = 3'd2;
	localparam logic [2:0] MODE_HOLD  = 3'd3;
	localparam logic [2:0] MODE_CHIRP = 3'd4;

	localparam logic [2:0] REG_MODE         = 3'd0;
	localparam logic [2:0] REG_LEVEL        = 3'd1;
	localparam logic [2:0] REG_PHASE_STEP   = 3'd2;
	localparam logic [2:0] REG_PHASE_OFFSET = 3'd3;
	localparam logic [2:0] REG_CHIRP_RATE   = 3'd4;
	localparam logic [2:0] REG_SLOPE        = 3'd5;
	localparam logic [2:0] REG_START_SAMPLE = 3'd6;
	localparam logic [2:0] REG_STOP_SAMPLE  = 3'd7;

	localparam logic ACT_TICK = 1'b0;
	localparam logic ACT_SEEK = 1'b1;

	typedef struct packed {
		logic        action;
		logic [31:0] seek_index;
	} in_word_t;

	typedef struct packed {
		logic signed [31:0] sample;
		logic [31:0]        sample_index;
	} out_word_t;

	typedef struct packed {
		logic [2:0]         mode;
		logic signed [31:0] level;
		logic [31:0]        phase_step;
		logic [31:0]        phase_offset;
		logic signed [31:0] chirp_rate;
		logic signed [31:0] slope;
		logic [31:0]        start_sample;
		logic [31:0]        stop_sample;
	} cfg_t;

	typedef enum logic [1:0] {
		JOB_CONST,
		JOB_RAMP,
		JOB_SINE,
		JOB_CHIRP
	} job_kind_t;

	typedef struct packed {
		job_kind_t   kind;
		logic [31:0] n;
		logic [31:0] span;
	} job_t;

	typedef struct packed {
		logic full;
		logic empty;
	} queue_stat_t;

	typedef enum logic [3:0] {
		BK_IDLE,
		BK_PH1,
		BK_PH2,
		BK_PH3,
		BK_PH4,
		BK_IDX,
		BK_ROM,
		BK_AMP,
		BK_RAMP,
		BK_FIN
	} back_state_t;

endpackage

@@ hw/rtl/twg_stream_if.sv @@
// Valid/ready stream channel carrying one payload word.
interface twg_stream_if #(
	parameter type payload_t = logic
) ();
	logic     valid;
	logic     ready;
	payload_t payload;

	modport source (output valid, output payload, input ready);
	modport sink   (input valid, input payload, output ready);
endinterface

@@ hw/rtl/twg_front.sv @@
// Front end: sample counter, seek handling and classification of ticks into jobs.
module twg_front
	import twg_pkg::*;
(
	input  logic         clk,
	input  logic         arst_n,
	twg_stream_if.sink   item,
	input  cfg_t         cfg,
	input  queue_stat_t  q_stat,
	output logic         push,
	output job_t         push_job
);

	logic [31:0] n_q;
	logic        accept;
	logic        gt_start;
	logic        le_stop;
	logic        stop_gt_start;

	assign item.ready = !q_stat.full;
	assign accept     = item.valid && item.ready;
	assign push       = accept && (item.payload.action == ACT_TICK);

	assign gt_start      = n_q > cfg.start_sample;
	assign le_stop       = n_q <= cfg.stop_sample;
	assign stop_gt_start = cfg.stop_sample > cfg.start_sample;

	always_comb begin
		push_job.n    = n_q;
		push_job.kind = JOB_CONST;
		push_job.span = n_q - cfg.start_sample;
		case (cfg.mode)
			MODE_SINE: begin
				push_job.kind = JOB_SINE;
			end
			MODE_CHIRP: begin
				push_job.kind = JOB_CHIRP;
			end
			MODE_RAMP: begin
				if (gt_start) push_job.kind = JOB_RAMP;
			end
			MODE_HOLD: begin
				if (gt_start && le_stop) begin
					push_job.kind = JOB_RAMP;
				end else if (gt_start && stop_gt_start) begin
					// past the stop point: freeze at the value reached there
					push_job.kind = JOB_RAMP;
					push_job.span = cfg.stop_sample - cfg.start_sample;
				end
			end
			default: begin
				push_job.kind = JOB_CONST;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			n_q <= '0;
		end else if (accept) begin
			if (item.payload.action == ACT_SEEK) n_q <= item.payload.seek_index;
			else n_q <= n_q + 32'd1;
		end
	end

endmodule

@@ hw/rtl/twg_queue.sv @@
// Short job queue between the front end and the back end.
module twg_queue
	import twg_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	input  job_t        push_job,
	input  logic        pop,
	output job_t        pop_job,
	output queue_stat_t q_stat
);

	job_t              slot_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QPTR_W:0]   count_q;

	assign q_stat.full  = count_q == (QPTR_W+1)'(QUEUE_DEPTH);
	assign q_stat.empty = count_q == '0;
	assign pop_job      = slot_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) slot_q[wr_ptr_q] <= push_job;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) wr_ptr_q <= wr_ptr_q + 1'b1;
			if (pop)  rd_ptr_q <= rd_ptr_q + 1'b1;
			if (push && !pop)      count_q <= count_q + 1'b1;
			else if (pop && !push) count_q <= count_q - 1'b1;
		end
	end

endmodule

@@ hw/rtl/twg_back.sv @@
// Back end: shared multiplier sequence, sine ROM, saturation and result register.
module twg_back
	import twg_pkg::*;
#(
	parameter int SINE_TABLE_DEPTH = 1024
) (
	input  logic          clk,
	input  logic          arst_n,
	input  cfg_t          cfg,
	input  queue_stat_t   q_stat,
	input  job_t          pop_job,
	output logic          pop,
	twg_stream_if.source  result
);

	localparam int IDX_W = $clog2(SINE_TABLE_DEPTH);

	// Q1.15 sine entry for phase p, built from a Q30 Taylor series.
	function automatic logic signed [15:0] sine_entry(input logic [31:0] p);
		logic [63:0] r;
		logic [63:0] x;
		logic [63:0] x2;
		logic [63:0] t;
		logic [63:0] s;
		logic [63:0] v;
		r = {34'd0, p[29:0]};
		if (p[30]) r = 64'd1073741824 - r;
		x  = (r * 64'd1686629713) >> 30;
		x2 = (x * x) >> 30;
		t  = 64'd1073741824 - x2 / 64'd110;
		t  = 64'd1073741824 - ((x2 * t) >> 30) / 64'd72;
		t  = 64'd1073741824 - ((x2 * t) >> 30) / 64'd42;
		t  = 64'd1073741824 - ((x2 * t) >> 30) / 64'd20;
		t  = 64'd1073741824 - ((x2 * t) >> 30) / 64'd6;
		s  = (x * t) >> 30;
		v  = (s * 64'd32767 + 64'd536870912) >> 30;
		if (v > 64'd32767) v = 64'd32767;
		sine_entry = p[31] ? -$signed(v[15:0]) : $signed(v[15:0]);
	endfunction

	logic signed [15:0] sine_rom [SINE_TABLE_DEPTH];

	for (genvar k = 0; k < SINE_TABLE_DEPTH; k++) begin : g_rom
		localparam logic [31:0] PHASE_K = 32'((64'(k) << 32) / SINE_TABLE_DEPTH);
		assign sine_rom[k] = sine_entry(PHASE_K);
	end

	back_state_t        state_q;
	back_state_t        state_d;
	job_t               job_q;
	logic signed [65:0] prod_q;
	logic [31:0]        acc_q;
	logic signed [15:0] rom_q;
	logic [IDX_W-1:0]   rom_addr;
	logic               res_valid_q;
	out_word_t          res_q;

	logic               mul_en;
	logic signed [32:0] mul_a;
	logic signed [32:0] mul_b;
	logic               acc_ld;
	logic [31:0]        acc_d;
	logic               fin_load;
	logic               out_free;
	logic signed [65:0] fin_v;
	logic [31:0]        fin_sat;

	assign out_free = !res_valid_q || result.ready;
	assign rom_addr = prod_q[32 +: IDX_W];

	always_comb begin
		state_d = state_q;
		case (state_q)
			BK_IDLE: begin
				if (!q_stat.empty) begin
					case (pop_job.kind)
						JOB_CONST: state_d = BK_FIN;
						JOB_RAMP:  state_d = BK_RAMP;
						default:   state_d = BK_PH1;
					endcase
				end
			end
			BK_PH1:  state_d = BK_PH2;
			BK_PH2:  state_d = BK_PH3;
			BK_PH3:  state_d = BK_PH4;
			BK_PH4:  state_d = BK_IDX;
			BK_IDX:  state_d = BK_ROM;
			BK_ROM:  state_d = BK_AMP;
			BK_AMP:  state_d = BK_FIN;
			BK_RAMP: state_d = BK_FIN;
			BK_FIN: begin
				if (out_free) state_d = BK_IDLE;
			end
			default: state_d = BK_IDLE;
		endcase
	end

	always_comb begin
		pop      = 1'b0;
		mul_en   = 1'b0;
		mul_a    = '0;
		mul_b    = '0;
		acc_ld   = 1'b0;
		acc_d    = acc_q;
		fin_load = 1'b0;
		case (state_q)
			BK_IDLE: begin
				pop = !q_stat.empty;
			end
			BK_PH1: begin
				mul_en = 1'b1;
				mul_a  = {1'b0, cfg.phase_step};
				mul_b  = {1'b0, job_q.n};
			end
			BK_PH2: begin
				acc_ld = 1'b1;
				acc_d  = cfg.phase_offset + prod_q[31:0];
				mul_en = 1'b1;
				mul_a  = {1'b0, job_q.n};
				mul_b  = {1'b0, job_q.n};
			end
			BK_PH3: begin
				// chirp term only in chirp mode; low word of n*n is all that counts
				mul_en = 1'b1;
				mul_a  = (job_q.kind == JOB_CHIRP) ? {1'b0, cfg.chirp_rate} : '0;
				mul_b  = {1'b0, prod_q[31:0]};
			end
			BK_PH4: begin
				acc_ld = 1'b1;
				acc_d  = acc_q + prod_q[31:0];
			end
			BK_IDX: begin
				mul_en = 1'b1;
				mul_a  = {1'b0, acc_q};
				mul_b  = 33'(SINE_TABLE_DEPTH);
			end
			BK_AMP: begin
				mul_en = 1'b1;
				mul_a  = {cfg.level[31], cfg.level};
				mul_b  = {{17{rom_q[15]}}, rom_q};
			end
			BK_RAMP: begin
				mul_en = 1'b1;
				mul_a  = {cfg.slope[31], cfg.slope};
				mul_b  = {1'b0, job_q.span};
			end
			BK_FIN: begin
				fin_load = out_free;
			end
			default: begin
				pop = 1'b0;
			end
		endcase
	end

	always_comb begin
		case (job_q.kind)
			JOB_RAMP:  fin_v = prod_q + {{34{cfg.level[31]}}, cfg.level};
			JOB_SINE:  fin_v = prod_q >>> 15;
			JOB_CHIRP: fin_v = prod_q >>> 15;
			default:   fin_v = {{34{cfg.level[31]}}, cfg.level};
		endcase
		if (&fin_v[65:31] || ~|fin_v[65:31]) fin_sat = fin_v[31:0];
		else if (fin_v[65])                  fin_sat = 32'h8000_0000;
		else                                 fin_sat = 32'h7fff_ffff;
	end

	always_ff @(posedge clk) begin
		if (pop)    job_q  <= pop_job;
		if (mul_en) prod_q <= mul_a * mul_b;
		if (acc_ld) acc_q  <= acc_d;
		rom_q <= sine_rom[rom_addr];
		if (fin_load) begin
			res_q.sample       <= $signed(fin_sat);
			res_q.sample_index <= job_q.n;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= BK_IDLE;
			res_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (fin_load)          res_valid_q <= 1'b1;
			else if (result.ready) res_valid_q <= 1'b0;
		end
	end

	assign result.valid   = res_valid_q;
	assign result.payload = res_q;

endmodule

@@ hw/rtl/test_waveform_generator_top.sv @@
// Tick-driven waveform generator. Each tick word on item yields one result word holding the
// sample for the current sample index n and n itself, after which n advances by one; a seek
// word loads n and yields nothing. The front end takes one word per cycle while its 4-entry
// job queue has room. The back end runs one job at a time through a single shared 33x33
// multiplier and a registered sine ROM: constant jobs go to the result step, ramps take one
// multiply, sine and chirp run phase, index, ROM and amplitude steps; that sequence sets the
// sustained rate. A finished word waits in an output register while the next job runs. The user
// must write configuration via cfg_we/cfg_index/cfg_data while idle; the block doesn't check.
module test_waveform_generator_top
	import twg_pkg::*;
#(
	parameter int SINE_TABLE_DEPTH = 1024
) (
	input  logic         clk,
	input  logic         arst_n,
	twg_stream_if.sink   item,
	twg_stream_if.source result,
	input  logic         cfg_we,
	input  logic [2:0]   cfg_index,
	input  logic [31:0]  cfg_data
);

	cfg_t        cfg_q;
	logic        q_push;
	job_t        push_job;
	logic        q_pop;
	job_t        pop_job;
	queue_stat_t q_stat;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '{stop_sample: 32'hffff_ffff, default: '0};
		end else if (cfg_we) begin
			case (cfg_index)
				REG_MODE:         cfg_q.mode         <= cfg_data[2:0];
				REG_LEVEL:        cfg_q.level        <= $signed(cfg_data);
				REG_PHASE_STEP:   cfg_q.phase_step   <= cfg_data;
				REG_PHASE_OFFSET: cfg_q.phase_offset <= cfg_data;
				REG_CHIRP_RATE:   cfg_q.chirp_rate   <= $signed(cfg_data);
				REG_SLOPE:        cfg_q.slope        <= $signed(cfg_data);
				REG_START_SAMPLE: cfg_q.start_sample <= cfg_data;
				REG_STOP_SAMPLE:  cfg_q.stop_sample  <= cfg_data;
				default:          cfg_q.mode         <= cfg_q.mode;
			endcase
		end
	end

	twg_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.item     (item),
		.cfg      (cfg_q),
		.q_stat   (q_stat),
		.push     (q_push),
		.push_job (push_job)
	);

	twg_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (q_push),
		.push_job (push_job),
		.pop      (q_pop),
		.pop_job  (pop_job),
		.q_stat   (q_stat)
	);

	twg_back #(
		.SINE_TABLE_DEPTH (SINE_TABLE_DEPTH)
	) u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.cfg     (cfg_q),
		.q_stat  (q_stat),
		.pop_job (pop_job),
		.pop     (q_pop),
		.result  (result)
	);

	a_no_push_full: assert property (@(posedge clk) disable iff (!arst_n)
		q_push |-> !q_stat.full)
		else $error("job pushed into a full queue");

	a_no_pop_empty: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> !q_stat.empty)
		else $error("job popped from an empty queue");

	a_ramp_job_mode: assert property (@(posedge clk) disable iff (!arst_n)
		(q_push && push_job.kind == JOB_RAMP) |->
			(cfg_q.mode == MODE_RAMP || cfg_q.mode == MODE_HOLD))
		else $error("ramp job issued outside a ramp mode");

endmodule

@@ test/tb.sv @@
`timescale 1ns / 1ps
// Self-checking testbench for the tick-driven waveform generator: predicts every sample word.
module tb;
	import twg_pkg::*;

	localparam int TABLE_DEPTH = 1024;
	localparam int CYCLE_LIMIT = 400000;
	localparam int RANDOM_WORDS = 1250;
	localparam int DRAIN_CYCLES = 24;
	localparam longint unsigned Q30 = 64'd1073741824;
	localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;
	localparam longint unsigned TAYLOR_DIV [4] = '{64'd72, 64'd42, 64'd20, 64'd6};

	class sample_scoreboard;
		cfg_t        regs;
		logic [31:0] n_count;
		shortint     sine_rom [TABLE_DEPTH];
		out_word_t   due_samples [$];
		int          faults;

		function new();
			longint unsigned p;
			regs = '0;
			regs.stop_sample = '1;
			n_count = '0;
			faults = 0;
			for (int k = 0; k < TABLE_DEPTH; k++) begin
				p = (longint'(k) << 32) / TABLE_DEPTH;
				sine_rom[k] = sine_value(p[31:0]);
			end
		endfunction

		// polynomial sine in Q30, rounded to Q1.15
		function shortint sine_value(logic [31:0] p);
			longint unsigned r, x, x2, t, s, v;
			r = {34'b0, p[29:0]};
			if (p[30])
				r = Q30 - r;
			x = (r * HALF_PI_Q30) >> 30;
			x2 = (x * x) >> 30;
			t = Q30 - x2 / 110;
			for (int i = 0; i < 4; i++)
				t = Q30 - ((x2 * t) >> 30) / TAYLOR_DIV[i];
			s = (x * t) >> 30;
			v = (s * 64'd32767 + (Q30 >> 1)) >> 30;
			if (v > 64'd32767)
				v = 64'd32767;
			return p[31] ? -shortint'(v) : shortint'(v);
		endfunction

		function logic signed [31:0] sat32(longint v);
			if (v > longint'(32'sh7FFFFFFF))
				return 32'sh7FFFFFFF;
			if (v < -longint'(64'h80000000))
				return 32'sh80000000;
			return v[31:0];
		endfunction

		function logic signed [31:0] scaled_sine(logic [31:0] phase);
			longint unsigned ix;
			longint prod;
			ix = ({32'b0, phase} * 64'(TABLE_DEPTH)) >> 32;
			if (ix >= 64'(TABLE_DEPTH))
				ix = 64'(TABLE_DEPTH - 1);
			prod = longint'(regs.level) * longint'(sine_rom[ix]);
			return sat32(prod >>> 15);
		endfunction

		function longint ramp_at(logic [31:0] n);
			logic [31:0] d;
			d = n - regs.start_sample;
			return longint'(regs.level) + longint'(regs.slope) * longint'({32'b0, d});
		endfunction

		function void write_reg(logic [2:0] idx, logic [31:0] d);
			case (idx)
				REG_MODE:         regs.mode = d[2:0];
				REG_LEVEL:        regs.level = d;
				REG_PHASE_STEP:   regs.phase_step = d;
				REG_PHASE_OFFSET: regs.phase_offset = d;
				REG_CHIRP_RATE:   regs.chirp_rate = d;
				REG_SLOPE:        regs.slope = d;
				REG_START_SAMPLE: regs.start_sample = d;
				REG_STOP_SAMPLE:  regs.stop_sample = d;
				default: ;
			endcase
		endfunction

		function void note_word(in_word_t w);
			out_word_t   e;
			logic [31:0] n;
			logic [31:0] ph;
			n = n_count;
			if (w.action == ACT_SEEK) begin
				n_count = w.seek_index;
				return;
			end
			case (regs.mode)
				MODE_SINE: begin
					ph = regs.phase_offset + regs.phase_step * n;
					e.sample = scaled_sine(ph);
				end
				MODE_CHIRP: begin
					ph = regs.phase_offset + regs.phase_step * n + regs.chirp_rate * (n * n);
					e.sample = scaled_sine(ph);
				end
				MODE_RAMP:
					e.sample = (n <= regs.start_sample) ? regs.level : sat32(ramp_at(n));
				MODE_HOLD: begin
					if (n <= regs.start_sample)
						e.sample = regs.level;
					else if (n <= regs.stop_sample)
						e.sample = sat32(ramp_at(n));
					else if (regs.stop_sample > regs.start_sample)
						e.sample = sat32(ramp_at(regs.stop_sample));
					else
						e.sample = regs.level;
				end
				default:
					e.sample = regs.level;
			endcase
			e.sample_index = n;
			due_samples.push_back(e);
			n_count = n + 1;
		endfunction

		function void check_word(out_word_t got);
			out_word_t e;
			if (due_samples.size() == 0) begin
				$error("unexpected word: sample %0d, sample_index %0d",
					got.sample, got.sample_index);
				faults++;
				return;
			end
			e = due_samples.pop_front();
			if (got.sample !== e.sample) begin
				$error("sample: expected %0d, got %0d", e.sample, got.sample);
				faults++;
			end
			if (got.sample_index !== e.sample_index) begin
				$error("sample_index: expected %0d, got %0d", e.sample_index, got.sample_index);
				faults++;
			end
		endfunction

		function int pending();
			return due_samples.size();
		endfunction
	endclass

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_we;
	logic [2:0]  cfg_index;
	logic [31:0] cfg_data;
	int          send_idle = 6;
	int          recv_idle = 69;
	int          words_sent = 0;
	int          cycle_count = 0;
	sample_scoreboard book;

	twg_stream_if #(.payload_t(in_word_t))  item_ch ();
	twg_stream_if #(.payload_t(out_word_t)) result_ch ();

	test_waveform_generator_top #(.SINE_TABLE_DEPTH(TABLE_DEPTH)) uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.item      (item_ch),
		.result    (result_ch),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always #6 clk = ~clk;

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("test_waveform_generator_top regression: fail");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (result_ch.valid && result_ch.ready)
				book.check_word(result_ch.payload);
			result_ch.ready <= ($urandom_range(99) >= recv_idle);
		end else begin
			result_ch.ready <= 1'b0;
		end
	end

	task automatic write_reg(input logic [2:0] idx, input logic [31:0] d);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= d;
		@(posedge clk);
		book.write_reg(idx, d);
	endtask

	task automatic load_regs(input cfg_t c, input logic [28:0] junk);
		write_reg(REG_MODE, {junk, c.mode});
		write_reg(REG_LEVEL, c.level);
		write_reg(REG_PHASE_STEP, c.phase_step);
		write_reg(REG_PHASE_OFFSET, c.phase_offset);
		write_reg(REG_CHIRP_RATE, c.chirp_rate);
		write_reg(REG_SLOPE, c.slope);
		write_reg(REG_START_SAMPLE, c.start_sample);
		write_reg(REG_STOP_SAMPLE, c.stop_sample);
		cfg_we <= 1'b0;
	endtask

	task automatic push_word(input in_word_t w);
		while ($urandom_range(99) < send_idle) begin
			item_ch.valid <= 1'b0;
			@(posedge clk);
		end
		item_ch.valid <= 1'b1;
		item_ch.payload <= w;
		do
			@(posedge clk);
		while (!item_ch.ready);
		book.note_word(w);
		words_sent++;
	endtask

	task automatic tick(input int count);
		in_word_t w;
		for (int i = 0; i < count; i++) begin
			w.action = ACT_TICK;
			w.seek_index = $urandom;
			push_word(w);
		end
	endtask

	task automatic seek(input logic [31:0] at);
		in_word_t w;
		w.action = ACT_SEEK;
		w.seek_index = at;
		push_word(w);
	endtask

	// drain, then idle before the next configuration
	task automatic settle();
		item_ch.valid <= 1'b0;
		while (book.pending() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	function automatic logic [31:0] pick32();
		case ($urandom_range(7))
			0: return 32'h0;
			1: return 32'hFFFFFFFF;
			2: return 32'h80000000;
			3: return 32'h7FFFFFFF;
			4: return $urandom_range(16);
			5: return -$urandom_range(16);
			default: return $urandom;
		endcase
	endfunction

	function automatic cfg_t random_cfg();
		cfg_t c;
		c.mode = ($urandom_range(99) < 8) ? 3'($urandom_range(7, 5)) : 3'($urandom_range(4));
		c.level = pick32();
		c.phase_step = $urandom_range(1) ? $urandom : pick32();
		c.phase_offset = $urandom_range(1) ? $urandom : pick32();
		c.chirp_rate = $urandom_range(1) ? 32'($urandom_range(4000)) - 32'd2000 : pick32();
		c.slope = pick32();
		c.start_sample = pick32();
		if ($urandom_range(2) != 0)
			c.stop_sample = c.start_sample + $urandom_range(40) - 10;
		else
			c.stop_sample = pick32();
		return c;
	endfunction

	// seek targets that land near the interesting indices
	function automatic logic [31:0] aim(input cfg_t c);
		case ($urandom_range(5))
			0: return c.start_sample - $urandom_range(8);
			1: return c.stop_sample - $urandom_range(8);
			2: return 32'hFFFFFFFF - $urandom_range(8);
			3: return $urandom_range(16);
			default: return $urandom;
		endcase
	endfunction

	initial begin
		cfg_t c;
		int   base;
		int   run;
		int   r;
		book = new();
		item_ch.valid = 1'b0;
		item_ch.payload = '0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// registers at their reset values
		tick(1);
		settle();

		// constant at the negative extreme, counter wrap
		c = '0;
		c.stop_sample = '1;
		c.mode = MODE_CONST;
		c.level = 32'sh80000000;
		load_regs(c, '0);
		seek(32'hFFFFFFFE);
		tick(3);
		settle();

		// sine, quarter turn per sample
		c.mode = MODE_SINE;
		c.level = 32'sh7FFFFFFF;
		c.phase_step = 32'h40000000;
		load_regs(c, '0);
		seek(32'h0);
		tick(4);
		settle();

		c.mode = MODE_CHIRP;
		c.level = 32'sh80000000;
		c.phase_step = 32'hFFFFFFFF;
		c.phase_offset = 32'h80000000;
		c.chirp_rate = 32'sh80000000;
		load_regs(c, '0);
		seek(32'h1);
		tick(2);
		settle();

		// ramp flat up to start, then saturating
		c = '0;
		c.stop_sample = '1;
		c.mode = MODE_RAMP;
		c.level = 32'sh7FFFFFFF;
		c.slope = 32'sh7FFFFFFF;
		c.start_sample = 32'd5;
		load_regs(c, '0);
		seek(32'd5);
		tick(2);
		settle();

		// ramp and hold through the hold value
		c.mode = MODE_HOLD;
		c.level = '0;
		c.slope = 32'sh80000000;
		c.start_sample = 32'd2;
		c.stop_sample = 32'd4;
		load_regs(c, '0);
		seek(32'd2);
		tick(4);
		settle();

		// stop at or below start holds level
		c.level = 32'sd1234;
		c.slope = 32'sd5;
		c.start_sample = 32'd10;
		c.stop_sample = 32'd3;
		load_regs(c, '0);
		seek(32'd11);
		tick(1);
		settle();

		// unused mode code, junk above the mode field
		c.mode = 3'd7;
		c.level = 32'sd42;
		load_regs(c, 29'h1ABCDEF5);
		tick(1);
		settle();

		base = words_sent;
		while (words_sent - base < RANDOM_WORDS) begin
			if (words_sent - base < RANDOM_WORDS / 3) begin
				send_idle = 6;
				recv_idle = 69;
			end else if (words_sent - base < 2 * RANDOM_WORDS / 3) begin
				send_idle = 69;
				recv_idle = 6;
			end else begin
				send_idle = 0;
				recv_idle = 0;
			end
			c = random_cfg();
			load_regs(c, ($urandom_range(99) < 20) ? 29'($urandom) : '0);
			run = $urandom_range(60, 10);
			for (int i = 0; i < run; i++) begin
				r = $urandom_range(99);
				if ((i == 0 && r < 85) || r < 4)
					seek(aim(c));
				else if (r < 8)
					seek($urandom);
				else
					tick(1);
			end
			settle();
		end

		if (book.faults == 0)
			$display("test_waveform_generator_top regression: pass");
		else
			$display("test_waveform_generator_top regression: fail");
		$finish;
	end

endmodule
